FILE: hw/rtl/pts_pkg.sv
// Shared types and constants for the periodic task scheduler.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package pts_pkg;

    // Table size and the width of a slot index
    localparam int NUM_SLOTS = 8;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // Field widths fixed by the item format
    localparam int OP_W     = 2;
    localparam int ID_W     = 8;
    localparam int PERIOD_W = 16;
    localparam int SLOTF_W  = 3;
    localparam int DIV_W    = 8;

    localparam logic [DIV_W-1:0] TICK_DIVIDE_RESET = 8'd10;

    // Item kinds
    typedef enum logic [OP_W-1:0] {
        OP_ADD      = 2'd0,
        OP_PULSE    = 2'd1,
        OP_DISPATCH = 2'd2,
        OP_DONE     = 2'd3
    } op_t;

    // Slot status codes
    typedef enum logic [1:0] {
        ST_STOPPED  = 2'd0,
        ST_RUNNABLE = 2'd1,
        ST_RUNNING  = 2'd2,
        ST_OVERRUN  = 2'd3
    } status_t;

    // One result item
    typedef struct packed {
        logic               ok;
        logic [SLOTF_W-1:0] slot;
        logic [ID_W-1:0]    task_id;
        logic               overrun;
    } res_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic prescale;
        logic scan_step;
        logic done_step;
        logic push;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        op_t  op;
        logic hit;
        logic last;
        logic tick_fire;
    } sts_t;

endpackage

FILE: hw/rtl/pts_in_if.sv
// Input item channel of the task scheduler.
// Depends on pts_pkg for field widths.
`timescale 1ns / 1ps

interface pts_in_if;
    logic                          valid;
    logic                          ready;
    logic [pts_pkg::OP_W-1:0]      op;
    logic [pts_pkg::ID_W-1:0]      task_id;
    logic [pts_pkg::PERIOD_W-1:0]  period;
    logic [pts_pkg::SLOTF_W-1:0]   slot;

    modport source (output valid, op, task_id, period, slot, input ready);
    modport sink   (input valid, op, task_id, period, slot, output ready);
endinterface

FILE: hw/rtl/pts_out_if.sv
// Result item channel of the task scheduler.
// Depends on pts_pkg for field widths.
`timescale 1ns / 1ps

interface pts_out_if;
    logic                          valid;
    logic                          ready;
    logic                          ok;
    logic [pts_pkg::SLOTF_W-1:0]   out_slot;
    logic [pts_pkg::ID_W-1:0]      out_task_id;
    logic                          overrun;

    modport source (output valid, ok, out_slot, out_task_id, overrun, input ready);
    modport sink   (input valid, ok, out_slot, out_task_id, overrun, output ready);
endinterface

FILE: hw/rtl/pts_cfg_if.sv
// Configuration write channel carrying the tick divider value.
// Depends on pts_pkg for the data width.
`timescale 1ns / 1ps

interface pts_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [pts_pkg::DIV_W-1:0]   data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: hw/rtl/pts_dp.sv
// Datapath of the task scheduler: slot table, prescaler, divider register,
// pending result and output payload register. Depends on pts_pkg.
`timescale 1ns / 1ps

module pts_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pts_pkg::cmd_t                 cmd,
    output pts_pkg::sts_t                 sts,
    input  logic [pts_pkg::OP_W-1:0]      op,
    input  logic [pts_pkg::ID_W-1:0]      task_id,
    input  logic [pts_pkg::PERIOD_W-1:0]  period,
    input  logic [pts_pkg::SLOTF_W-1:0]   slot,
    input  logic                          cfg_valid,
    input  logic [pts_pkg::DIV_W-1:0]     cfg_data,
    output pts_pkg::res_t                 out_res
);

    localparam logic [pts_pkg::SLOT_W-1:0] LAST_IDX = pts_pkg::SLOT_W'(pts_pkg::NUM_SLOTS - 1);

    // Slot table
    logic [pts_pkg::ID_W-1:0]     slot_id_reg        [pts_pkg::NUM_SLOTS];
    logic [pts_pkg::PERIOD_W-1:0] slot_period_reg    [pts_pkg::NUM_SLOTS];
    logic [pts_pkg::PERIOD_W-1:0] slot_countdown_reg [pts_pkg::NUM_SLOTS];
    pts_pkg::status_t             slot_status_reg    [pts_pkg::NUM_SLOTS];

    // Item, walk index, prescaler and results
    pts_pkg::op_t                  op_reg;
    logic [pts_pkg::ID_W-1:0]      id_in_reg;
    logic [pts_pkg::PERIOD_W-1:0]  period_in_reg;
    logic [pts_pkg::SLOTF_W-1:0]   slot_in_reg;
    logic [pts_pkg::SLOT_W-1:0]    idx_reg;
    logic [pts_pkg::DIV_W-1:0]     prescale_reg;
    logic [pts_pkg::DIV_W-1:0]     tick_divide_reg;
    pts_pkg::res_t                 res_reg;
    pts_pkg::res_t                 out_reg;

    // Current slot view
    pts_pkg::status_t              cur_status;
    logic [pts_pkg::PERIOD_W-1:0]  cur_cd;
    logic [pts_pkg::PERIOD_W-1:0]  cd_dec;
    logic [pts_pkg::DIV_W:0]       presc_next;
    logic                          done_ok;

    // Decode the slot at the walk index
    always_comb
    begin
        cur_status = slot_status_reg[idx_reg];
        cur_cd     = slot_countdown_reg[idx_reg];
        cd_dec     = (cur_cd != '0) ? (cur_cd - 1'b1) : cur_cd;
        presc_next = {1'b0, prescale_reg} + 1'b1;
        done_ok    = (int'(slot_in_reg) < pts_pkg::NUM_SLOTS) &&
                     ((cur_status == pts_pkg::ST_RUNNING) ||
                      (cur_status == pts_pkg::ST_OVERRUN));
    end

    // Report status to the controller
    always_comb
    begin
        sts.op        = op_reg;
        sts.last      = (idx_reg == LAST_IDX);
        sts.tick_fire = (presc_next >= {1'b0, tick_divide_reg});
        sts.hit       = ((op_reg == pts_pkg::OP_ADD) &&
                         (cur_status == pts_pkg::ST_STOPPED)) ||
                        ((op_reg == pts_pkg::OP_DISPATCH) &&
                         (cur_status == pts_pkg::ST_RUNNABLE) && (cur_cd == '0));
    end

    assign out_res = out_reg;

    // Hold the table and item state; apply one slot step per command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < pts_pkg::NUM_SLOTS; k++)
            begin
                slot_id_reg[k]        <= '0;
                slot_period_reg[k]    <= '0;
                slot_countdown_reg[k] <= '0;
                slot_status_reg[k]    <= pts_pkg::ST_STOPPED;
            end
            op_reg          <= pts_pkg::OP_ADD;
            id_in_reg       <= '0;
            period_in_reg   <= '0;
            slot_in_reg     <= '0;
            idx_reg         <= '0;
            prescale_reg    <= '0;
            tick_divide_reg <= pts_pkg::TICK_DIVIDE_RESET;
            res_reg         <= '0;
            out_reg         <= '0;
        end
        else
        begin
            // Write the divider register
            if (cfg_valid)
            begin
                tick_divide_reg <= cfg_data;
            end

            // Capture an accepted item and clear the pending result
            if (cmd.load)
            begin
                op_reg        <= pts_pkg::op_t'(op);
                id_in_reg     <= task_id;
                period_in_reg <= period;
                slot_in_reg   <= slot;
                idx_reg       <= (pts_pkg::op_t'(op) == pts_pkg::OP_DONE) ?
                                 pts_pkg::SLOT_W'(slot) : '0;
                res_reg       <= '0;
            end

            // Advance the prescaler
            if (cmd.prescale)
            begin
                if (sts.tick_fire)
                begin
                    prescale_reg <= '0;
                    res_reg.ok   <= 1'b1;
                end
                else
                begin
                    prescale_reg <= presc_next[pts_pkg::DIV_W-1:0];
                end
            end

            // Process one slot of an add, dispatch or tick walk
            if (cmd.scan_step)
            begin
                idx_reg <= idx_reg + 1'b1;
                unique case (op_reg)
                    pts_pkg::OP_ADD:
                    begin
                        if (sts.hit)
                        begin
                            slot_id_reg[idx_reg]        <= id_in_reg;
                            slot_period_reg[idx_reg]    <= period_in_reg;
                            slot_countdown_reg[idx_reg] <= period_in_reg;
                            slot_status_reg[idx_reg]    <= pts_pkg::ST_RUNNABLE;
                            res_reg.ok   <= 1'b1;
                            res_reg.slot <= pts_pkg::SLOTF_W'(idx_reg);
                        end
                    end
                    pts_pkg::OP_DISPATCH:
                    begin
                        if (sts.hit)
                        begin
                            slot_status_reg[idx_reg]    <= pts_pkg::ST_RUNNING;
                            slot_countdown_reg[idx_reg] <= slot_period_reg[idx_reg];
                            res_reg.ok      <= 1'b1;
                            res_reg.slot    <= pts_pkg::SLOTF_W'(idx_reg);
                            res_reg.task_id <= slot_id_reg[idx_reg];
                        end
                    end
                    pts_pkg::OP_PULSE:
                    begin
                        slot_countdown_reg[idx_reg] <= cd_dec;
                        if ((cur_status == pts_pkg::ST_RUNNING) && (cd_dec == '0))
                        begin
                            slot_status_reg[idx_reg] <= pts_pkg::ST_OVERRUN;
                        end
                    end
                    pts_pkg::OP_DONE:
                    begin
                        // Done never walks the table
                    end
                endcase
            end

            // Retire a finished task
            if (cmd.done_step && done_ok)
            begin
                slot_status_reg[idx_reg] <= pts_pkg::ST_RUNNABLE;
                res_reg.ok      <= 1'b1;
                res_reg.slot    <= slot_in_reg;
                res_reg.task_id <= slot_id_reg[idx_reg];
                res_reg.overrun <= (cur_status == pts_pkg::ST_OVERRUN);
            end

            // Move the pending result to the output register
            if (cmd.push)
            begin
                out_reg <= res_reg;
            end
        end
    end

endmodule

FILE: hw/rtl/pts_ctrl.sv
// Controller state machine of the task scheduler: sequences one item through
// the datapath and owns both handshakes. Depends on pts_pkg.
`timescale 1ns / 1ps

module pts_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  pts_pkg::sts_t sts,
    output pts_pkg::cmd_t cmd
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_ROUTE    = 6'b000010,
        S_PRESCALE = 6'b000100,
        S_SCAN     = 6'b001000,
        S_DONE     = 6'b010000,
        S_POST     = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Sequence the item and issue datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_ROUTE;
                end
            end
            S_ROUTE:
            begin
                // Route the loaded item by its kind
                unique case (sts.op)
                    pts_pkg::OP_PULSE:    state_next = S_PRESCALE;
                    pts_pkg::OP_DONE:     state_next = S_DONE;
                    pts_pkg::OP_ADD:      state_next = S_SCAN;
                    pts_pkg::OP_DISPATCH: state_next = S_SCAN;
                endcase
            end
            S_PRESCALE:
            begin
                cmd.prescale = 1'b1;
                state_next = sts.tick_fire ? S_SCAN : S_POST;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.hit || sts.last)
                begin
                    state_next = S_POST;
                end
            end
            S_DONE:
            begin
                cmd.done_step = 1'b1;
                state_next = S_POST;
            end
            S_POST:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.push = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on push, drop on transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.push)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (!out_valid_reg || out_ready))
        else $error("result pushed over an untaken result");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> out_valid_reg)
        else $error("pushed result not presented");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) && !sts.hit && !sts.last |=> (state_reg == S_SCAN))
        else $error("slot walk ended early");

endmodule

FILE: hw/rtl/periodic_task_scheduler_unit.sv
// Periodic task scheduler: a controller and a datapath joined by commands.
// Depends on pts_pkg, pts_in_if, pts_out_if, pts_cfg_if, pts_ctrl, pts_dp.
//
// Usage
//   req carries one item per transfer: op (add, timebase pulse, dispatch,
//   done), task_id and period for add, slot for done. rsp returns exactly one
//   result per item: ok, out_slot, out_task_id, overrun. cfg writes the tick
//   divider (pulses per scheduler tick); it is always ready, and the user
//   must write it only while the block is idle, which is not enforced.
// Sequencing
//   Items are handled one at a time. Done passes the route and done states
//   before its result goes to the output register. Add and dispatch walk the
//   slots one per cycle until a match or the last slot. A pulse that ends
//   in a tick walks every slot; any other pulse only advances the prescaler.
// Reset
//   All slots stopped, countdowns and prescaler zero, divider 10.
// Stalls
//   The result sits in an output register; the next item is taken while it
//   waits, and its result is held until rsp transfers the first.
`timescale 1ns / 1ps

module periodic_task_scheduler_unit (
    input  logic       clk,
    input  logic       rst_n,
    pts_in_if.sink     req,
    pts_out_if.source  rsp,
    pts_cfg_if.sink    cfg
);

    pts_pkg::cmd_t cmd;
    pts_pkg::sts_t sts;
    pts_pkg::res_t out_res;

    pts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pts_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .op        (req.op),
        .task_id   (req.task_id),
        .period    (req.period),
        .slot      (req.slot),
        .cfg_valid (cfg.valid),
        .cfg_data  (cfg.data),
        .out_res   (out_res)
    );

    // Divider register takes a write in any cycle
    assign cfg.ready = 1'b1;

    // Drive the result payload
    assign rsp.ok          = out_res.ok;
    assign rsp.out_slot    = out_res.slot;
    assign rsp.out_task_id = out_res.task_id;
    assign rsp.overrun     = out_res.overrun;

endmodule
